>>> rtl/core/sfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants of the star glob matcher
// op codes, character constants, pointer commands and the control structs
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int PATTERN_DEPTH_DEF   = 64;
    localparam int CANDIDATE_DEPTH_DEF = 256;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD_PAT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CAND = 2'd1;
    localparam logic [OP_W-1:0] OP_MATCH     = 2'd2;

    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

    // pointer commands from the controller to the datapath
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_INIT  = 3'd1;
    localparam logic [2:0] PTR_ADV   = 3'd2;
    localparam logic [2:0] PTR_ESC   = 3'd3;
    localparam logic [2:0] PTR_STAR  = 3'd4;
    localparam logic [2:0] PTR_RETRY = 3'd5;
    localparam logic [2:0] PTR_SKIP  = 3'd6;
    localparam logic [2:0] PTR_TAIL  = 3'd7;

    typedef struct packed {
        logic       wr_pat;
        logic       wr_cand;
        logic [2:0] ptr_op;
        logic       finish;
        logic       result;
    } sfm_cmd_t;

    typedef struct packed {
        logic c_zero;
        logic p_zero;
        logic p_star;
        logic p_esc;
        logic c_eq_p;
        logic lit;
        logic have_star;
    } sfm_status_t;

endpackage

>>> rtl/core/sfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_if: request and response channels of the star glob matcher
// valid/ready handshake, one item moves when both are high
// ----------------------------------------------------------------------------
interface sfm_req_if;
    logic                        valid;
    logic                        ready;
    logic [sfm_pkg::OP_W-1:0]    op;
    logic [sfm_pkg::BYTE_W-1:0]  byte_value;
    logic                        first_byte;

    modport source (output valid, output op, output byte_value, output first_byte,
                    input ready);
    modport sink   (input valid, input op, input byte_value, input first_byte,
                    output ready);
endinterface

interface sfm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic truncated;

    modport source (output valid, output matched, output truncated, input ready);
    modport sink   (input valid, input matched, input truncated, output ready);
endinterface

>>> rtl/core/sfm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_datapath: stores, lengths, match pointers and result register
// executes load writes and pointer commands, reports byte compare status
// ----------------------------------------------------------------------------
module sfm_datapath #(
    parameter int PATTERN_DEPTH   = sfm_pkg::PATTERN_DEPTH_DEF,
    parameter int CANDIDATE_DEPTH = sfm_pkg::CANDIDATE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfm_pkg::sfm_cmd_t          cmd,
    input  logic [sfm_pkg::BYTE_W-1:0] byte_value,
    input  logic                       first_byte,
    output sfm_pkg::sfm_status_t       status,
    output logic                       matched,
    output logic                       truncated
);
    import sfm_pkg::*;

    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int CLW = $clog2(CANDIDATE_DEPTH + 1);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CAW = (CANDIDATE_DEPTH > 1) ? $clog2(CANDIDATE_DEPTH) : 1;

    logic [BYTE_W-1:0] pat_mem  [PATTERN_DEPTH];
    logic [BYTE_W-1:0] cand_mem [CANDIDATE_DEPTH];
    logic [BYTE_W-1:0] pat_q;
    logic [BYTE_W-1:0] cand_q;

    logic [PLW-1:0] plen_reg, plen_next;
    logic [CLW-1:0] clen_reg, clen_next;
    logic           ovf_reg, ovf_next;
    logic [PLW-1:0] pa_reg, pa_next, rp_reg, rp_next;
    logic [CLW-1:0] ca_reg, ca_next, rc_reg, rc_next;
    logic           have_star_reg, have_star_next;
    logic           lit_reg, lit_next;
    logic           matched_reg, matched_next;
    logic           trunc_reg, trunc_next;

    logic [PLW-1:0]    p_base;
    logic [CLW-1:0]    c_base;
    logic              p_room;
    logic              c_room;
    logic [BYTE_W-1:0] p_val;
    logic [BYTE_W-1:0] c_val;

    // write position: restart at zero on a first byte
    assign p_base = first_byte ? '0 : plen_reg;
    assign c_base = first_byte ? '0 : clen_reg;
    assign p_room = p_base < PLW'(PATTERN_DEPTH);
    assign c_room = c_base < CLW'(CANDIDATE_DEPTH);

    always_comb
    begin
        plen_next    = plen_reg;
        clen_next    = clen_reg;
        ovf_next     = ovf_reg;
        matched_next = matched_reg;
        trunc_next   = trunc_reg;
        if (cmd.wr_pat)
        begin
            if (p_room)
            begin
                plen_next = p_base + PLW'(1);
            end
            else
            begin
                plen_next = p_base;
                ovf_next  = 1'b1;
            end
        end
        if (cmd.wr_cand)
        begin
            if (c_room)
            begin
                clen_next = c_base + CLW'(1);
            end
            else
            begin
                clen_next = c_base;
                ovf_next  = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            matched_next = cmd.result;
            trunc_next   = ovf_reg;
            ovf_next     = 1'b0;
        end
    end

    always_comb
    begin
        pa_next        = pa_reg;
        ca_next        = ca_reg;
        rp_next        = rp_reg;
        rc_next        = rc_reg;
        have_star_next = have_star_reg;
        lit_next       = 1'b0;
        case (cmd.ptr_op)
            PTR_HOLD:
            begin
                lit_next = lit_reg;
            end
            PTR_INIT:
            begin
                pa_next        = '0;
                ca_next        = '0;
                rp_next        = '0;
                rc_next        = '0;
                have_star_next = 1'b0;
            end
            PTR_ADV:
            begin
                pa_next = pa_reg + PLW'(1);
                ca_next = ca_reg + CLW'(1);
            end
            PTR_ESC:
            begin
                pa_next  = pa_reg + PLW'(1);
                lit_next = 1'b1;
            end
            PTR_STAR:
            begin
                have_star_next = 1'b1;
                rc_next        = ca_reg;
                rp_next        = pa_reg + PLW'(1);
                pa_next        = pa_reg + PLW'(1);
            end
            PTR_RETRY:
            begin
                pa_next = rp_reg;
                ca_next = rc_reg;
            end
            PTR_SKIP:
            begin
                rc_next = rc_reg + CLW'(1);
                ca_next = rc_reg + CLW'(1);
                pa_next = rp_reg;
            end
            PTR_TAIL:
            begin
                pa_next = pa_reg + PLW'(1);
            end
            default:
            begin
                lit_next = lit_reg;
            end
        endcase
    end

    // stores: read follows the next pointer so data lines up with the pointer
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pat && p_room)
        begin
            pat_mem[p_base[PAW-1:0]] <= byte_value;
        end
        pat_q <= pat_mem[pa_next[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cand && c_room)
        begin
            cand_mem[c_base[CAW-1:0]] <= byte_value;
        end
        cand_q <= cand_mem[ca_next[CAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            clen_reg      <= '0;
            ovf_reg       <= 1'b0;
            pa_reg        <= '0;
            ca_reg        <= '0;
            rp_reg        <= '0;
            rc_reg        <= '0;
            have_star_reg <= 1'b0;
            lit_reg       <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            clen_reg      <= clen_next;
            ovf_reg       <= ovf_next;
            pa_reg        <= pa_next;
            ca_reg        <= ca_next;
            rp_reg        <= rp_next;
            rc_reg        <= rc_next;
            have_star_reg <= have_star_next;
            lit_reg       <= lit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        trunc_reg   <= trunc_next;
    end

    // bytes past the loaded length read as the end mark
    assign p_val = (pa_reg < plen_reg) ? pat_q : CH_NUL;
    assign c_val = (ca_reg < clen_reg) ? cand_q : CH_NUL;

    assign status.c_zero    = (c_val == CH_NUL);
    assign status.p_zero    = (p_val == CH_NUL);
    assign status.p_star    = (p_val == CH_STAR);
    assign status.p_esc     = (p_val == CH_ESC);
    assign status.c_eq_p    = (c_val == p_val);
    assign status.lit       = lit_reg;
    assign status.have_star = have_star_reg;

    assign matched   = matched_reg;
    assign truncated = trunc_reg;

endmodule

>>> rtl/core/sfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_ctrl: sequencer of the star glob matcher
// takes request items, steps the greedy match, owns the response valid
// ----------------------------------------------------------------------------
module sfm_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [sfm_pkg::OP_W-1:0] req_op,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  sfm_pkg::sfm_status_t     status,
    output sfm_pkg::sfm_cmd_t        cmd
);
    import sfm_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CMP     = 3'd1;
    localparam logic [2:0] ST_STARCHK = 3'd2;
    localparam logic [2:0] ST_TAIL    = 3'd3;
    localparam logic [2:0] ST_FIN     = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       fin_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign fin_fire  = (state_reg == ST_FIN) && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        cmd.wr_pat  = 1'b0;
        cmd.wr_cand = 1'b0;
        cmd.ptr_op  = PTR_HOLD;
        cmd.finish  = 1'b0;
        cmd.result  = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_op)
                        OP_LOAD_PAT:  cmd.wr_pat  = 1'b1;
                        OP_LOAD_CAND: cmd.wr_cand = 1'b1;
                        OP_MATCH:
                        begin
                            cmd.ptr_op = PTR_INIT;
                            state_next = ST_CMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP:
            begin
                if (status.c_zero)
                begin
                    state_next = ST_TAIL;
                end
                else if (!status.lit && status.p_star)
                begin
                    cmd.ptr_op = PTR_STAR;
                    state_next = ST_STARCHK;
                end
                else if (!status.lit && status.p_esc)
                begin
                    cmd.ptr_op = PTR_ESC;
                end
                else if (status.p_zero || !status.c_eq_p)
                begin
                    if (status.have_star)
                    begin
                        cmd.ptr_op = PTR_SKIP;
                    end
                    else
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    cmd.ptr_op = PTR_ADV;
                end
            end
            ST_STARCHK:
            begin
                if (status.p_zero)
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.ptr_op = PTR_RETRY;
                    state_next = ST_CMP;
                end
            end
            ST_TAIL:
            begin
                if (status.p_zero)
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (!status.p_star)
                begin
                    res_next   = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.ptr_op = PTR_TAIL;
                end
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = fin_fire || (out_valid_reg && !rsp_ready);
    assign rsp_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

>>> rtl/core/star_glob_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_glob_matcher_core: star-only glob matcher with pattern and candidate stores
// decides whether a loaded candidate string matches a loaded '*' glob pattern
// ----------------------------------------------------------------------------
// usage
//   req carries items of op, byte_value and first_byte. op load pattern or load
//   candidate appends one byte to that store (first_byte restarts it at length
//   zero); bytes past a store's depth are dropped and flagged. op match walks
//   both stores and gives one item on rsp: matched and truncated (any byte
//   dropped since reset or the previous match). unused op codes are taken and
//   ignored.
// throughput and match steps
//   load items are taken one per cycle while no match is running. a match steps
//   the sequencer through compare, escape or skip steps, a star check after
//   each star, the candidate end, a tail step per trailing star, the pattern
//   end and the report; no new item is taken until the result moves to the
//   output register.
// reset
//   lengths and the drop flag clear; store contents stay undefined and are
//   only read below the loaded lengths.
// stalls
//   the result sits in an output register; while rsp is stalled new loads and
//   a new match are still taken, and a later result waits for the slot.
// ----------------------------------------------------------------------------
module star_glob_matcher_core #(
    parameter int PATTERN_DEPTH   = sfm_pkg::PATTERN_DEPTH_DEF,
    parameter int CANDIDATE_DEPTH = sfm_pkg::CANDIDATE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sfm_req_if.sink   req,
    sfm_rsp_if.source rsp
);
    import sfm_pkg::*;

    sfm_cmd_t    cmd;
    sfm_status_t status;

    // sequencer: request handshake, match steps, response valid
    sfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, pointers and result bits
    sfm_datapath #(
        .PATTERN_DEPTH   (PATTERN_DEPTH),
        .CANDIDATE_DEPTH (CANDIDATE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_value (req.byte_value),
        .first_byte (req.first_byte),
        .status     (status),
        .matched    (rsp.matched),
        .truncated  (rsp.truncated)
    );

endmodule
